FILE: rtl/core/pwp_pkg.sv
`timescale 1ns / 1ps

package pwp_pkg;

  // Ownership state codes.
  localparam logic [2:0] ST_NOT_OWNED    = 3'd0;
  localparam logic [2:0] ST_REMOVAL_WAIT = 3'd1;
  localparam logic [2:0] ST_PRESS_WAIT   = 3'd2;
  localparam logic [2:0] ST_FAILED       = 3'd3;
  localparam logic [2:0] ST_OWNED        = 3'd4;

  // Action codes of an input word.
  localparam logic [1:0] ACT_CHECK   = 2'd0;
  localparam logic [1:0] ACT_PROOF   = 2'd1;
  localparam logic [1:0] ACT_FORCE   = 2'd2;
  localparam logic [1:0] ACT_FOLLOW  = 2'd3;

  // Request codes.
  localparam logic [1:0] FLAG_NONE   = 2'd0;
  localparam logic [1:0] FLAG_SET    = 2'd1;
  localparam logic [1:0] FLAG_CLEAR  = 2'd2;
  localparam logic [1:0] DET_NONE    = 2'd0;
  localparam logic [1:0] DET_START   = 2'd1;
  localparam logic [1:0] DET_ABORT   = 2'd2;
  localparam logic [1:0] SLEEP_NONE  = 2'd0;
  localparam logic [1:0] SLEEP_ALLOW = 2'd1;
  localparam logic [1:0] SLEEP_BLOCK = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DELAY_REQUIRED = 2'd0;
  localparam logic [1:0] CFG_REMOVAL_DELAY  = 2'd1;
  localparam logic [1:0] CFG_PRESS_TIMEOUT  = 2'd2;

  // Reset values: two and five minutes in microseconds.
  localparam logic [31:0] REMOVAL_DELAY_RST = 32'd120000000;
  localparam logic [31:0] PRESS_TIMEOUT_RST = 32'd300000000;

  typedef struct packed {
    logic [1:0]  action;
    logic        battery_present;
    logic        saved_ownership;
    logic        detect_busy;
    logic        forced_level;
    logic [63:0] now;
  } item_t;

  typedef struct packed {
    logic        owner_proven;
    logic        protect_level;
    logic        forcing_level;
    logic [2:0]  owner_state;
    logic [1:0]  flag_request;
    logic [1:0]  detect_request;
    logic [1:0]  sleep_request;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_wr_t;

endpackage

FILE: rtl/core/presence_write_protect_fsm.sv
`timescale 1ns / 1ps

// A word accepted into the input register is evaluated there and loaded into
// the result register, where its result word waits until it is taken.
// Throughput: one word per cycle unless out_ready stalls it; the state update
// and the result load happen together, so the next word always sees the new state.
// Reset (rst_n low, synchronous): state not owned, deadlines zero, protect
// asserted, forcing off, configuration back to its defaults, both stages empty.
module presence_write_protect_fsm (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic        in_battery_present,
  input  logic        in_saved_ownership,
  input  logic        in_detect_busy,
  input  logic        in_forced_level,
  input  logic [63:0] in_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_owner_proven,
  output logic        out_protect_level,
  output logic        out_forcing_level,
  output logic [2:0]  out_owner_state,
  output logic [1:0]  out_flag_request,
  output logic [1:0]  out_detect_request,
  output logic [1:0]  out_sleep_request,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  pwp_pkg::item_t   in_item;
  pwp_pkg::item_t   item;
  pwp_pkg::result_t result;
  pwp_pkg::result_t out_result;
  pwp_pkg::cfg_wr_t cfg_wr;
  logic             item_valid;
  logic             can_load;
  logic             fire;

  // Configuration writes are always taken; the user must let them arrive only while idle, unenforced by the block.
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  assign in_item.action          = in_action;
  assign in_item.battery_present = in_battery_present;
  assign in_item.saved_ownership = in_saved_ownership;
  assign in_item.detect_busy     = in_detect_busy;
  assign in_item.forced_level    = in_forced_level;
  assign in_item.now             = in_now;

  // A word is evaluated when one sits in the input register and the result
  // register is free or being emptied in this cycle.
  assign fire = item_valid && can_load;

  pwp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .consume    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  pwp_eval u_eval (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  pwp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .result     (result),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign out_owner_proven   = out_result.owner_proven;
  assign out_protect_level  = out_result.protect_level;
  assign out_forcing_level  = out_result.forcing_level;
  assign out_owner_state    = out_result.owner_state;
  assign out_flag_request   = out_result.flag_request;
  assign out_detect_request = out_result.detect_request;
  assign out_sleep_request  = out_result.sleep_request;

endmodule

FILE: rtl/core/pwp_in_stage.sv
`timescale 1ns / 1ps

// Input register: holds one word until the evaluation stage consumes it.
module pwp_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pwp_pkg::item_t in_item,
  input  logic          consume,
  output logic          item_valid,
  output pwp_pkg::item_t item
);

  logic           valid_r;
  logic           valid_nxt;
  pwp_pkg::item_t item_r;

  assign in_ready  = !valid_r || consume;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (consume ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: rtl/core/pwp_eval.sv
`timescale 1ns / 1ps

// Ownership state, deadlines, protect level and configuration registers,
// with the one-pass next-state logic for a word.
module pwp_eval (
  input  logic             clk,
  input  logic             rst_n,
  input  pwp_pkg::cfg_wr_t cfg_wr,
  input  logic             fire,
  input  pwp_pkg::item_t   item,
  output pwp_pkg::result_t result
);

  logic        delay_req_r;
  logic [31:0] removal_delay_r;
  logic [31:0] press_timeout_r;

  logic [2:0]  state_r,   state_nxt;
  logic [63:0] rdl_r,     rdl_nxt;
  logic [63:0] pdl_r,     pdl_nxt;
  logic        protect_r, protect_nxt;
  logic        forcing_r, forcing_nxt;

  // Evaluation results.
  logic [2:0]  ev_state;
  logic [63:0] ev_rdl;
  logic [63:0] ev_pdl;
  logic        ev_owned;
  logic [1:0]  ev_flag;
  logic [1:0]  ev_det;
  logic [1:0]  ev_sleep;

  logic [2:0]  st_eff;
  logic [31:0] addend;
  logic [63:0] deadline_sum;
  logic [63:0] deadline_cmp;
  logic        passed;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_req_r     <= 1'b1;
      removal_delay_r <= pwp_pkg::REMOVAL_DELAY_RST;
      press_timeout_r <= pwp_pkg::PRESS_TIMEOUT_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        pwp_pkg::CFG_DELAY_REQUIRED: delay_req_r     <= cfg_wr.data[0];
        pwp_pkg::CFG_REMOVAL_DELAY:  removal_delay_r <= cfg_wr.data;
        pwp_pkg::CFG_PRESS_TIMEOUT:  press_timeout_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // Without the delay, or with the saved flag, the state is forced to owned.
  assign st_eff = (!delay_req_r || item.saved_ownership) ? pwp_pkg::ST_OWNED : state_r;

  // One shared adder and one shared compare serve both deadlines.
  assign addend       = (st_eff == pwp_pkg::ST_NOT_OWNED) ? removal_delay_r : press_timeout_r;
  assign deadline_sum = item.now + {32'd0, addend};
  assign deadline_cmp = (st_eff == pwp_pkg::ST_REMOVAL_WAIT) ? rdl_r : pdl_r;
  assign passed       = item.now >= deadline_cmp;

  always_comb begin
    ev_state = st_eff;
    ev_rdl   = rdl_r;
    ev_pdl   = pdl_r;
    ev_owned = 1'b0;
    ev_flag  = pwp_pkg::FLAG_NONE;
    ev_det   = pwp_pkg::DET_NONE;
    ev_sleep = pwp_pkg::SLEEP_NONE;
    if (item.battery_present) begin
      if (state_r == pwp_pkg::ST_PRESS_WAIT) begin
        ev_det = pwp_pkg::DET_ABORT;
      end
      if (item.saved_ownership) begin
        ev_flag = pwp_pkg::FLAG_CLEAR;
      end
      if (delay_req_r) begin
        ev_sleep = pwp_pkg::SLEEP_ALLOW;
      end
      ev_state = pwp_pkg::ST_NOT_OWNED;
      ev_rdl   = 64'd0;
      ev_pdl   = 64'd0;
    end else begin
      unique case (st_eff)
        pwp_pkg::ST_OWNED: begin
          if (delay_req_r && !item.saved_ownership) begin
            ev_flag = pwp_pkg::FLAG_SET;
          end
          ev_owned = 1'b1;
          ev_sleep = pwp_pkg::SLEEP_ALLOW;
        end
        pwp_pkg::ST_NOT_OWNED: begin
          ev_rdl   = deadline_sum;
          ev_state = pwp_pkg::ST_REMOVAL_WAIT;
          ev_sleep = pwp_pkg::SLEEP_BLOCK;
        end
        pwp_pkg::ST_REMOVAL_WAIT: begin
          if (passed) begin
            if (item.detect_busy) begin
              ev_state = pwp_pkg::ST_FAILED;
            end else begin
              ev_pdl   = deadline_sum;
              ev_state = pwp_pkg::ST_PRESS_WAIT;
              ev_det   = pwp_pkg::DET_START;
            end
          end
        end
        pwp_pkg::ST_PRESS_WAIT: begin
          if (passed) begin
            ev_det   = pwp_pkg::DET_ABORT;
            ev_state = pwp_pkg::ST_FAILED;
          end
        end
        default: begin
          // Failed and the unused codes just allow deep sleep.
          ev_sleep = pwp_pkg::SLEEP_ALLOW;
        end
      endcase
    end
  end

  // Action dispatch and the result word.
  always_comb begin
    state_nxt   = state_r;
    rdl_nxt     = rdl_r;
    pdl_nxt     = pdl_r;
    protect_nxt = protect_r;
    forcing_nxt = forcing_r;
    result      = '0;
    unique case (item.action)
      pwp_pkg::ACT_CHECK: begin
        state_nxt = ev_state;
        rdl_nxt   = ev_rdl;
        pdl_nxt   = ev_pdl;
        if (!forcing_r) begin
          protect_nxt = !ev_owned;
        end
      end
      pwp_pkg::ACT_PROOF: begin
        state_nxt = pwp_pkg::ST_OWNED;
      end
      pwp_pkg::ACT_FORCE: begin
        forcing_nxt = 1'b1;
        protect_nxt = item.forced_level;
      end
      default: begin
        forcing_nxt = 1'b0;
        state_nxt   = ev_state;
        rdl_nxt     = ev_rdl;
        pdl_nxt     = ev_pdl;
        protect_nxt = !ev_owned;
      end
    endcase
    if (item.action == pwp_pkg::ACT_CHECK || item.action == pwp_pkg::ACT_FOLLOW) begin
      result.owner_proven   = ev_owned;
      result.flag_request   = ev_flag;
      result.detect_request = ev_det;
      result.sleep_request  = ev_sleep;
    end
    result.protect_level = protect_nxt;
    result.forcing_level = forcing_nxt;
    result.owner_state   = state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pwp_pkg::ST_NOT_OWNED;
      rdl_r     <= 64'd0;
      pdl_r     <= 64'd0;
      protect_r <= 1'b1;
      forcing_r <= 1'b0;
    end else if (fire) begin
      state_r   <= state_nxt;
      rdl_r     <= rdl_nxt;
      pdl_r     <= pdl_nxt;
      protect_r <= protect_nxt;
      forcing_r <= forcing_nxt;
    end
  end

endmodule

FILE: rtl/core/pwp_out_stage.sv
`timescale 1ns / 1ps

// Result register: a finished word waits here until it is taken.
module pwp_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  pwp_pkg::result_t result,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output pwp_pkg::result_t out_result
);

  logic             valid_r;
  logic             valid_nxt;
  pwp_pkg::result_t result_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

FILE: rtl/core/pwp_checker.sv
`timescale 1ns / 1ps

module pwp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_owner_proven,
  input logic       out_protect_level,
  input logic       out_forcing_level,
  input logic [2:0] out_owner_state,
  input logic [1:0] out_flag_request,
  input logic [1:0] out_detect_request
);

  // Ownership can only be reported from the owned state.
  a_owned_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_owner_proven) |-> (out_owner_state == pwp_pkg::ST_OWNED))
    else $error("owned result outside the owned state");

  // Unforced ownership always lifts write protect.
  a_owned_unprotect: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_owner_proven && !out_forcing_level) |-> !out_protect_level)
    else $error("write protect asserted while owned and not forced");

  // A button check starts only on entry to the press wait.
  a_start_press: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_detect_request == pwp_pkg::DET_START)
      |-> (out_owner_state == pwp_pkg::ST_PRESS_WAIT))
    else $error("button check started outside press wait");

  // Setting the saved flag goes with proven ownership.
  a_flag_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flag_request == pwp_pkg::FLAG_SET) |-> out_owner_proven)
    else $error("saved flag set without ownership");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_owner_state)
      && $stable(out_protect_level)))
    else $error("result word changed while stalled");

endmodule

bind presence_write_protect_fsm pwp_checker u_pwp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_owner_proven   (out_owner_proven),
  .out_protect_level  (out_protect_level),
  .out_forcing_level  (out_forcing_level),
  .out_owner_state    (out_owner_state),
  .out_flag_request   (out_flag_request),
  .out_detect_request (out_detect_request)
);
